// File: sv/cnlv_pkg.sv
// ----------------------------------------------------------------------------
// cnlv_pkg
// Types and constants shared by the card number Luhn validator modules.
// ----------------------------------------------------------------------------
package cnlv_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_CR    = 8'd13;

    localparam logic [4:0] MIN_LEN_RESET = 5'd13;
    localparam logic [4:0] MAX_LEN_RESET = 5'd19;
    localparam logic [4:0] COUNT_MAX     = 5'd31;

    localparam logic       CFG_MIN_LEN = 1'b0;
    localparam logic       CFG_MAX_LEN = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_CHAR  = 2'd1,
        ST_BAD_LEN   = 2'd2,
        ST_LUHN_FAIL = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        BR_OTHER      = 3'd0,
        BR_VISA       = 3'd1,
        BR_MASTERCARD = 3'd2,
        BR_MAESTRO    = 3'd3,
        BR_JCB        = 3'd4,
        BR_AMEX       = 3'd5
    } t_brand;

    typedef enum logic [1:0] {
        CK_BLANK = 2'd0,
        CK_DIGIT = 2'd1,
        CK_BAD   = 2'd2
    } t_char_kind;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        t_status    status;
        t_brand     brand;
        logic [4:0] digit_count;
    } t_out_item;

    typedef struct packed {
        t_char_kind kind;
        logic [3:0] digit;
        logic       last;
    } t_cls_item;

    typedef struct packed {
        logic      valid;
        t_cls_item item;
    } t_link;

endpackage

// File: sv/cnlv_front.sv
// ----------------------------------------------------------------------------
// cnlv_front
// Accepts characters, classifies them as blank, digit or bad, and holds the
// classified transactions in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module cnlv_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cnlv_pkg::t_in_item  i_item,
    output logic                o_full,
    output cnlv_pkg::t_link     o_link,
    input  logic                i_take
);

    cnlv_pkg::t_cls_item r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    cnlv_pkg::t_cls_item w_cls;
    logic                w_wr;
    logic                w_rd;
    logic [7:0]          w_digit_full;

    always_comb begin
        w_digit_full = i_item.char_code - cnlv_pkg::CHAR_ZERO;
        w_cls.digit  = w_digit_full[3:0];
        w_cls.last   = i_item.last_char;
        if (i_item.char_code >= cnlv_pkg::CHAR_ZERO &&
            i_item.char_code <= cnlv_pkg::CHAR_NINE) begin
            w_cls.kind = cnlv_pkg::CK_DIGIT;
        end else if (i_item.char_code == cnlv_pkg::CHAR_SPACE ||
                     (i_item.char_code >= cnlv_pkg::CHAR_TAB &&
                      i_item.char_code <= cnlv_pkg::CHAR_CR)) begin
            w_cls.kind = cnlv_pkg::CK_BLANK;
        end else begin
            w_cls.kind = cnlv_pkg::CK_BAD;
        end
    end

    assign o_full      = (r_cnt == 2'd2);
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_take && (r_cnt != 2'd0);
    assign o_link.valid = (r_cnt != 2'd0);
    assign o_link.item  = r_mem[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_wr && w_rd) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= w_cls;
        end
    end

endmodule

// File: sv/cnlv_back.sv
// ----------------------------------------------------------------------------
// cnlv_back
// Accumulates digit count, Luhn sums and leading digits per number, and on
// the last character pushes a result into a two-entry result queue.
// ----------------------------------------------------------------------------
module cnlv_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cnlv_pkg::t_link     i_link,
    output logic                o_take,
    input  logic [4:0]          i_min_len,
    input  logic [4:0]          i_max_len,
    output logic                o_empty,
    input  logic                i_pop,
    output cnlv_pkg::t_out_item o_item
);

    logic [4:0] r_count,     n_count;
    logic       r_bad,       n_bad;
    logic [3:0] r_sum_even,  n_sum_even;
    logic [3:0] r_sum_odd,   n_sum_odd;
    logic [3:0] r_lead,      n_lead;
    logic [3:0] r_second,    n_second;

    cnlv_pkg::t_out_item r_oq [2];
    logic       r_oq_wr;
    logic       r_oq_rd;
    logic [1:0] r_oq_cnt;

    cnlv_pkg::t_out_item w_res;
    logic [4:0] w_dbl;
    logic [4:0] w_add_e;
    logic [4:0] w_add_o;
    logic       w_oq_push;
    logic       w_oq_pop;
    logic [3:0] w_d;

    assign o_take    = i_link.valid && (!i_link.item.last || r_oq_cnt != 2'd2);
    assign w_oq_push = o_take && i_link.item.last;
    assign w_oq_pop  = i_pop && (r_oq_cnt != 2'd0);
    assign o_empty   = (r_oq_cnt == 2'd0);
    assign o_item    = r_oq[r_oq_rd];
    assign w_d       = i_link.item.digit;

    always_comb begin
        w_dbl   = (w_d < 4'd5) ? {w_d, 1'b0} : ({w_d, 1'b0} - 5'd9);
        w_add_e = {1'b0, r_sum_odd} + {1'b0, w_d};
        w_add_o = {1'b0, r_sum_even} + w_dbl;

        n_count    = r_count;
        n_bad      = r_bad;
        n_sum_even = r_sum_even;
        n_sum_odd  = r_sum_odd;
        n_lead     = r_lead;
        n_second   = r_second;

        case (i_link.item.kind)
            cnlv_pkg::CK_DIGIT: begin
                n_sum_even = (w_add_e >= 5'd10) ? 4'(w_add_e - 5'd10) : w_add_e[3:0];
                n_sum_odd  = (w_add_o >= 5'd10) ? 4'(w_add_o - 5'd10) : w_add_o[3:0];
                if (r_count == 5'd0) begin
                    n_lead = w_d;
                end else if (r_count == 5'd1) begin
                    n_second = w_d;
                end
                if (r_count != cnlv_pkg::COUNT_MAX) begin
                    n_count = r_count + 5'd1;
                end
            end
            cnlv_pkg::CK_BAD: begin
                n_bad = 1'b1;
            end
            default: begin
            end
        endcase

        if (n_bad) begin
            w_res.status = cnlv_pkg::ST_BAD_CHAR;
        end else if (n_count == 5'd0 || n_count < i_min_len || n_count > i_max_len) begin
            w_res.status = cnlv_pkg::ST_BAD_LEN;
        end else if (n_sum_even != 4'd0) begin
            w_res.status = cnlv_pkg::ST_LUHN_FAIL;
        end else begin
            w_res.status = cnlv_pkg::ST_OK;
        end

        case (n_lead)
            4'd3:    w_res.brand = (n_second == 4'd4 || n_second == 4'd7) ?
                                   cnlv_pkg::BR_AMEX : cnlv_pkg::BR_JCB;
            4'd4:    w_res.brand = cnlv_pkg::BR_VISA;
            4'd5:    w_res.brand = cnlv_pkg::BR_MASTERCARD;
            4'd6:    w_res.brand = cnlv_pkg::BR_MAESTRO;
            default: w_res.brand = cnlv_pkg::BR_OTHER;
        endcase

        w_res.digit_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= 5'd0;
            r_bad      <= 1'b0;
            r_sum_even <= 4'd0;
            r_sum_odd  <= 4'd0;
            r_lead     <= 4'd0;
            r_second   <= 4'd0;
        end else if (o_take) begin
            if (i_link.item.last) begin
                r_count    <= 5'd0;
                r_bad      <= 1'b0;
                r_sum_even <= 4'd0;
                r_sum_odd  <= 4'd0;
                r_lead     <= 4'd0;
                r_second   <= 4'd0;
            end else begin
                r_count    <= n_count;
                r_bad      <= n_bad;
                r_sum_even <= n_sum_even;
                r_sum_odd  <= n_sum_odd;
                r_lead     <= n_lead;
                r_second   <= n_second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_cnt <= 2'd0;
            r_oq_wr  <= 1'b0;
            r_oq_rd  <= 1'b0;
        end else begin
            if (w_oq_push && !w_oq_pop) begin
                r_oq_cnt <= r_oq_cnt + 2'd1;
            end else if (!w_oq_push && w_oq_pop) begin
                r_oq_cnt <= r_oq_cnt - 2'd1;
            end
            if (w_oq_push) begin
                r_oq_wr <= ~r_oq_wr;
            end
            if (w_oq_pop) begin
                r_oq_rd <= ~r_oq_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_oq_push) begin
            r_oq[r_oq_wr] <= w_res;
        end
    end

endmodule

// File: sv/card_number_luhn_validator.sv
// ----------------------------------------------------------------------------
// card_number_luhn_validator
// Streams card number text one character per transaction and reports Luhn
// status, brand and digit count on the last character.
// ----------------------------------------------------------------------------
// One character is taken every clock while the classify queue is not full.
// It goes into a two-entry classify queue, the accumulator takes it from
// the queue head, and a result is written into the result queue when its
// last character is accepted. The accumulator stalls only when a last
// character meets a full two-entry result queue; otherwise throughput is one
// character per cycle, set by the combinational mod-10 update. Length bounds
// are written through the config port: index 0 min length, 1 max length.
module card_number_luhn_validator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    input  cnlv_pkg::t_in_item  i_in_item,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output cnlv_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [4:0]          i_cfg_data
);

    logic [4:0]      r_min_len;
    logic [4:0]      r_max_len;
    cnlv_pkg::t_link w_link;
    logic            w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= cnlv_pkg::MIN_LEN_RESET;
            r_max_len <= cnlv_pkg::MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cnlv_pkg::CFG_MIN_LEN: r_min_len <= i_cfg_data;
                cnlv_pkg::CFG_MAX_LEN: r_max_len <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cnlv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_in_item),
        .o_full  (full),
        .o_link  (w_link),
        .i_take  (w_take)
    );

    cnlv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_link    (w_link),
        .o_take    (w_take),
        .i_min_len (r_min_len),
        .i_max_len (r_max_len),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_item    (o_out_item)
    );

    a_full_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> w_link.valid)
        else $error("classify queue full without a head item");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && $past(empty)) |-> $past(w_take && w_link.item.last))
        else $error("result appeared without a last character");

endmodule
